// ----- rtl/core/drr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drr_pkg
// Shared types, codes and the microcode word layout of the descriptor ring
// refill unit.
// ----------------------------------------------------------------------------
package drr_pkg;

    localparam int DEF_RING_DEPTH  = 32;
    localparam int DEF_CHUNK_BYTES = 65536;

    localparam int IDX_W     = 5;
    localparam int SAMPLES_W = 16;
    localparam int CHUNK_W   = 17;
    localparam int WIDE_W    = 9;
    localparam int PC_W      = 5;

    localparam logic [PC_W-1:0] PC_IDLE = 5'd0;
    localparam logic [PC_W-1:0] PC_LAST = 5'd28;

    localparam logic [31:0] ALIGN_MASK  = ~32'd3;
    localparam logic [31:0] MIN_ALIGNED = 32'd4;

    // Command codes
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_POLL  = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    // Channel actions
    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_RUN    = 2'd1;
    localparam logic [1:0] ACT_RESUME = 2'd2;
    localparam logic [1:0] ACT_STOP   = 2'd3;

    // Result kinds
    localparam logic KIND_DESC   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_BASE   = 2'd0;
    localparam logic [1:0] CFG_LENGTH = 2'd1;
    localparam logic [1:0] CFG_LOOP   = 2'd2;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LATCH,
        OP_EMIT_STATUS,
        OP_STOP,
        OP_START_INIT,
        OP_SET_ERR,
        OP_START_OK,
        OP_CIV_SUB,
        OP_ADV,
        OP_RETIRE,
        OP_POLL_ACT,
        OP_CLR_CURSOR,
        OP_REST,
        OP_CHUNK,
        OP_ADVANCE,
        OP_END_CHECK,
        OP_EMIT_DESC
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_CMD,
        C_IS_START,
        C_IS_POLL,
        C_IS_STOP,
        C_LEN_ZERO,
        C_QUEUED_ZERO,
        C_CH_IDLE,
        C_CIV_IN_RING,
        C_CIV_EQ_SEEN,
        C_FILL_DONE,
        C_CUR_LT_LEN,
        C_NO_WRAP
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic cmd_accept;
        logic is_start;
        logic is_poll;
        logic is_stop;
        logic len_zero;
        logic queued_zero;
        logic ch_idle;
        logic civ_in_ring;
        logic civ_eq_seen;
        logic fill_done;
        logic cur_lt_len;
        logic no_wrap;
        logic out_free;
    } flags_t;

    typedef struct packed {
        op_t  op;
        logic go;
    } ctrl_t;

    function automatic logic is_emit(op_t op);
        return (op == OP_EMIT_STATUS) || (op == OP_EMIT_DESC);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/dma_descriptor_ring_refill_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dma_descriptor_ring_refill_unit
// Producer of buffer descriptors for a DMA ring, run by a small microcode
// program.
// ----------------------------------------------------------------------------
// Usage:
//   Commands (start, poll, stop) arrive on the cmd_* channel with the engine's
//   current ring index and halted bit. Each command returns its descriptor
//   writes on the res_* channel, then one closing status transaction with
//   last set. The cfg_* channel writes base, length and loop mode; it is
//   always ready and must only be used while no command is in flight.
//   cmd_stall is high from acceptance until the closing status has
//   been loaded into the result register. Each descriptor passes through
//   a ring-full test, cursor test, subtract, chunk clamp, cursor add, end
//   test and emit, and each command adds its dispatch and status steps;
//   a wrap test and, in loop play, a cursor clear follow when the cursor
//   already sits at or past the length, and a poll subtracts the ring
//   depth step by step when reducing an out-of-range index.
//   The single output register decouples the sides: the next command is
//   taken while the last status still waits to be taken.
//   A stalled receiver holds the result register and the sequencer waits at
//   its emit step; nothing is dropped.
//   Reset clears the ring state, the configuration and the result register
//   and returns the sequencer to its idle step.
// ----------------------------------------------------------------------------
module dma_descriptor_ring_refill_unit
    import drr_pkg::*;
#(
    parameter int RING_DEPTH  = DEF_RING_DEPTH,
    parameter int CHUNK_BYTES = DEF_CHUNK_BYTES
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration write channel
    input  wire logic                 cfg_valid,
    output      logic                 cfg_ready,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [31:0]          cfg_data,
    // command channel
    input  wire logic                 cmd_valid,
    output      logic                 cmd_stall,
    input  wire logic [1:0]           command,
    input  wire logic [IDX_W-1:0]     current_index,
    input  wire logic                 channel_halted,
    // result channel
    output      logic                 res_valid,
    input  wire logic                 res_stall,
    output      logic                 kind,
    output      logic [IDX_W-1:0]     entry_index,
    output      logic [31:0]          entry_address,
    output      logic [SAMPLES_W-1:0] entry_samples,
    output      logic                 entry_interrupt,
    output      logic                 lvi_write,
    output      logic [IDX_W-1:0]     last_valid_index,
    output      logic [1:0]           channel_action,
    output      logic                 start_error,
    output      logic                 playing,
    output      logic                 last
);

    logic            cmd_accept;
    logic            busy;
    logic [PC_W-1:0] pc;
    ucode_t          word;
    ctrl_t           ctrl;
    flags_t          flags;

    // configuration must be written only between commands (not enforced here), so never push back
    assign cfg_ready  = 1'b1;

    // hold off new commands until the sequencer is back at its idle step
    assign cmd_stall  = busy;
    assign cmd_accept = cmd_valid && !cmd_stall;

    drr_ucode_rom u_rom
    (
        .pc   (pc),
        .word (word)
    );

    drr_sequencer u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .word  (word),
        .pc    (pc),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    drr_datapath
    #(
        .RING_DEPTH  (RING_DEPTH),
        .CHUNK_BYTES (CHUNK_BYTES)
    )
    u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd_accept       (cmd_accept),
        .command          (command),
        .current_index    (current_index),
        .channel_halted   (channel_halted),
        .ctrl             (ctrl),
        .res_stall        (res_stall),
        .flags            (flags),
        .res_valid        (res_valid),
        .kind             (kind),
        .entry_index      (entry_index),
        .entry_address    (entry_address),
        .entry_samples    (entry_samples),
        .entry_interrupt  (entry_interrupt),
        .lvi_write        (lvi_write),
        .last_valid_index (last_valid_index),
        .channel_action   (channel_action),
        .start_error      (start_error),
        .playing          (playing),
        .last             (last)
    );

endmodule
`default_nettype wire

// ----- rtl/core/drr_ucode_rom.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drr_ucode_rom
// Read-only control store: one control word per program step.
// ----------------------------------------------------------------------------
module drr_ucode_rom
    import drr_pkg::*;
(
    input  logic [PC_W-1:0] pc,
    output ucode_t          word
);

    localparam logic [PC_W-1:0] S_IDLE       = 5'd0;
    localparam logic [PC_W-1:0] S_STATUS     = 5'd4;
    localparam logic [PC_W-1:0] S_STOP       = 5'd5;
    localparam logic [PC_W-1:0] S_START      = 5'd6;
    localparam logic [PC_W-1:0] S_ERR        = 5'd8;
    localparam logic [PC_W-1:0] S_START_TAIL = 5'd9;
    localparam logic [PC_W-1:0] S_POLL       = 5'd11;
    localparam logic [PC_W-1:0] S_CIV_CHK    = 5'd12;
    localparam logic [PC_W-1:0] S_POLL_TAIL  = 5'd17;
    localparam logic [PC_W-1:0] S_FILL       = 5'd18;
    localparam logic [PC_W-1:0] S_CHUNK      = 5'd22;
    localparam logic [PC_W-1:0] S_FILL_END   = 5'd27;

    always_comb
    begin
        unique case (pc)
            // dispatch
            5'd0:  word = '{OP_LATCH,       C_NO_CMD,      S_IDLE};
            5'd1:  word = '{OP_NOP,         C_IS_START,    S_START};
            5'd2:  word = '{OP_NOP,         C_IS_POLL,     S_POLL};
            5'd3:  word = '{OP_NOP,         C_IS_STOP,     S_STOP};
            5'd4:  word = '{OP_EMIT_STATUS, C_ALWAYS,      S_IDLE};
            5'd5:  word = '{OP_STOP,        C_ALWAYS,      S_STATUS};
            // start
            5'd6:  word = '{OP_NOP,         C_LEN_ZERO,    S_ERR};
            5'd7:  word = '{OP_START_INIT,  C_ALWAYS,      S_FILL};
            5'd8:  word = '{OP_SET_ERR,     C_ALWAYS,      S_STATUS};
            5'd9:  word = '{OP_NOP,         C_QUEUED_ZERO, S_ERR};
            5'd10: word = '{OP_START_OK,    C_ALWAYS,      S_STATUS};
            // poll: unless idle, reduce index, retire, then refill
            5'd11: word = '{OP_NOP,         C_CH_IDLE,     S_STATUS};
            5'd12: word = '{OP_NOP,         C_CIV_IN_RING, 5'd14};
            5'd13: word = '{OP_CIV_SUB,     C_ALWAYS,      S_CIV_CHK};
            5'd14: word = '{OP_NOP,         C_CIV_EQ_SEEN, S_FILL};
            5'd15: word = '{OP_ADV,         C_NEVER,       S_IDLE};
            5'd16: word = '{OP_RETIRE,      C_ALWAYS,      S_FILL};
            5'd17: word = '{OP_POLL_ACT,    C_ALWAYS,      S_STATUS};
            // fill loop
            5'd18: word = '{OP_NOP,         C_FILL_DONE,   S_FILL_END};
            5'd19: word = '{OP_NOP,         C_CUR_LT_LEN,  S_CHUNK};
            5'd20: word = '{OP_NOP,         C_NO_WRAP,     S_FILL_END};
            5'd21: word = '{OP_CLR_CURSOR,  C_ALWAYS,      S_FILL};
            5'd22: word = '{OP_REST,        C_NEVER,       S_IDLE};
            5'd23: word = '{OP_CHUNK,       C_NEVER,       S_IDLE};
            5'd24: word = '{OP_ADVANCE,     C_NEVER,       S_IDLE};
            5'd25: word = '{OP_END_CHECK,   C_NEVER,       S_IDLE};
            5'd26: word = '{OP_EMIT_DESC,   C_ALWAYS,      S_FILL};
            5'd27: word = '{OP_NOP,         C_IS_START,    S_START_TAIL};
            5'd28: word = '{OP_NOP,         C_ALWAYS,      S_POLL_TAIL};
            default: word = '{OP_NOP,       C_ALWAYS,      S_IDLE};
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/core/drr_sequencer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drr_sequencer
// Step counter with conditional jumps; holds on an emit step while the
// result register is occupied.
// ----------------------------------------------------------------------------
module drr_sequencer
    import drr_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  flags_t          flags,
    input  ucode_t          word,
    output logic [PC_W-1:0] pc,
    output ctrl_t           ctrl,
    output logic            busy
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            cond_hit;
    logic            go;

    always_comb
    begin
        case (word.cond)
            C_NEVER:       cond_hit = 1'b0;
            C_ALWAYS:      cond_hit = 1'b1;
            C_NO_CMD:      cond_hit = !flags.cmd_accept;
            C_IS_START:    cond_hit = flags.is_start;
            C_IS_POLL:     cond_hit = flags.is_poll;
            C_IS_STOP:     cond_hit = flags.is_stop;
            C_LEN_ZERO:    cond_hit = flags.len_zero;
            C_QUEUED_ZERO: cond_hit = flags.queued_zero;
            C_CH_IDLE:     cond_hit = flags.ch_idle;
            C_CIV_IN_RING: cond_hit = flags.civ_in_ring;
            C_CIV_EQ_SEEN: cond_hit = flags.civ_eq_seen;
            C_FILL_DONE:   cond_hit = flags.fill_done;
            C_CUR_LT_LEN:  cond_hit = flags.cur_lt_len;
            C_NO_WRAP:     cond_hit = flags.no_wrap;
            default:       cond_hit = 1'b0;
        endcase
    end

    // emit steps wait for a free result register
    assign go = is_emit(word.op) ? flags.out_free : 1'b1;

    always_comb
    begin
        if (!go)
        begin
            pc_next = pc_reg;
        end
        else if (cond_hit)
        begin
            pc_next = word.target;
        end
        else
        begin
            pc_next = pc_reg + PC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign pc      = pc_reg;
    assign ctrl.op = word.op;
    assign ctrl.go = go;
    assign busy    = (pc_reg != PC_IDLE);

    a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= PC_LAST)
        else $error("step counter left the program");

    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (is_emit(word.op) && !flags.out_free) |=> $stable(pc_reg))
        else $error("sequencer advanced past a blocked emit");

    a_idle_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == PC_IDLE && !flags.cmd_accept) |=> (pc_reg == PC_IDLE))
        else $error("sequencer left idle without a command");

endmodule
`default_nettype wire

// ----- rtl/core/drr_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drr_datapath
// Ring state, chunk arithmetic, configuration registers and the result
// register, all driven by the current control word.
// ----------------------------------------------------------------------------
module drr_datapath
    import drr_pkg::*;
#(
    parameter int RING_DEPTH  = DEF_RING_DEPTH,
    parameter int CHUNK_BYTES = DEF_CHUNK_BYTES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 cmd_accept,
    input  logic [1:0]           command,
    input  logic [IDX_W-1:0]     current_index,
    input  logic                 channel_halted,
    input  ctrl_t                ctrl,
    input  logic                 res_stall,
    output flags_t               flags,
    output logic                 res_valid,
    output logic                 kind,
    output logic [IDX_W-1:0]     entry_index,
    output logic [31:0]          entry_address,
    output logic [SAMPLES_W-1:0] entry_samples,
    output logic                 entry_interrupt,
    output logic                 lvi_write,
    output logic [IDX_W-1:0]     last_valid_index,
    output logic [1:0]           channel_action,
    output logic                 start_error,
    output logic                 playing,
    output logic                 last
);

    localparam int SLOT_W = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam logic [WIDE_W-1:0] DEPTH_W   = WIDE_W'(RING_DEPTH);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_DEPTH - 1);
    localparam logic [31:0]       CHUNK_V   = 32'(CHUNK_BYTES);
    localparam logic [31:0]       CHUNK_TOP = CHUNK_V & ALIGN_MASK;

    // configuration
    logic [31:0] base_reg;
    logic [31:0] len_reg;
    logic        loop_reg;

    // ring state
    logic [31:0]       cursor_reg,    cursor_next;
    logic              producing_reg, producing_next;
    logic              looping_reg,   looping_next;
    logic [SLOT_W-1:0] wslot_reg,     wslot_next;
    logic [SLOT_W-1:0] seen_reg,      seen_next;
    logic [CNT_W-1:0]  queued_reg,    queued_next;

    // per-command working registers
    logic [1:0]        cmd_reg,    cmd_next;
    logic [IDX_W-1:0]  civ_reg,    civ_next;
    logic              halted_reg, halted_next;
    logic [1:0]        act_reg,    act_next;
    logic              err_reg,    err_next;
    logic              lviw_reg,   lviw_next;
    logic [SLOT_W-1:0] lvi_reg,    lvi_next;
    logic [31:0]       rest_reg,   rest_next;
    logic [31:0]       addr_reg,   addr_next;
    logic [CHUNK_W-1:0] chunk_reg, chunk_next;
    logic              irq_reg,    irq_next;
    logic [WIDE_W-1:0] adv_reg,    adv_next;

    // result register
    logic                 res_valid_reg, res_valid_next;
    logic                 r_kind_reg,    r_kind_next;
    logic [IDX_W-1:0]     r_idx_reg,     r_idx_next;
    logic [31:0]          r_addr_reg,    r_addr_next;
    logic [SAMPLES_W-1:0] r_smp_reg,     r_smp_next;
    logic                 r_irq_reg,     r_irq_next;
    logic                 r_lviw_reg,    r_lviw_next;
    logic [IDX_W-1:0]     r_lvi_reg,     r_lvi_next;
    logic [1:0]           r_act_reg,     r_act_next;
    logic                 r_err_reg,     r_err_next;
    logic                 r_play_reg,    r_play_next;
    logic                 r_last_reg,    r_last_next;

    logic [WIDE_W-1:0] civ_w;
    logic [WIDE_W-1:0] seen_w;
    logic [WIDE_W-1:0] wslot_w;
    logic [WIDE_W-1:0] queued_w;
    logic [WIDE_W-1:0] lvi_w;
    logic [WIDE_W-1:0] adv_sum;
    logic [SLOT_W-1:0] wslot_inc;
    logic [SLOT_W-1:0] wslot_dec;
    logic              out_free;
    logic              play_now;
    logic              per_entry;

    assign civ_w     = WIDE_W'(civ_reg);
    assign seen_w    = WIDE_W'(seen_reg);
    assign wslot_w   = WIDE_W'(wslot_reg);
    assign queued_w  = WIDE_W'(queued_reg);
    assign lvi_w     = WIDE_W'(lvi_reg);
    assign adv_sum   = civ_w + DEPTH_W - seen_w;
    assign wslot_inc = (wslot_reg == LAST_SLOT) ? '0 : wslot_reg + SLOT_W'(1);
    assign wslot_dec = (wslot_reg == '0) ? LAST_SLOT : wslot_reg - SLOT_W'(1);
    assign out_free  = !res_valid_reg || !res_stall;
    assign play_now  = producing_reg || (queued_reg != '0) || !halted_reg;
    assign per_entry = (cmd_reg == CMD_POLL);

    always_comb
    begin
        flags.cmd_accept  = cmd_accept;
        flags.is_start    = (cmd_reg == CMD_START);
        flags.is_poll     = (cmd_reg == CMD_POLL);
        flags.is_stop     = (cmd_reg == CMD_STOP);
        flags.len_zero    = (len_reg == '0);
        flags.queued_zero = (queued_reg == '0);
        flags.ch_idle     = !producing_reg && (queued_reg == '0);
        flags.civ_in_ring = (civ_w < DEPTH_W);
        flags.civ_eq_seen = (civ_w == seen_w);
        flags.fill_done   = (queued_w >= DEPTH_W) || !producing_reg;
        flags.cur_lt_len  = (cursor_reg < len_reg);
        flags.no_wrap     = !(looping_reg && (len_reg != '0));
        flags.out_free    = out_free;
    end

    always_comb
    begin
        cursor_next    = cursor_reg;
        producing_next = producing_reg;
        looping_next   = looping_reg;
        wslot_next     = wslot_reg;
        seen_next      = seen_reg;
        queued_next    = queued_reg;
        cmd_next       = cmd_reg;
        civ_next       = civ_reg;
        halted_next    = halted_reg;
        act_next       = act_reg;
        err_next       = err_reg;
        lviw_next      = lviw_reg;
        lvi_next       = lvi_reg;
        rest_next      = rest_reg;
        addr_next      = addr_reg;
        chunk_next     = chunk_reg;
        irq_next       = irq_reg;
        adv_next       = adv_reg;

        res_valid_next = res_valid_reg && res_stall;
        r_kind_next    = r_kind_reg;
        r_idx_next     = r_idx_reg;
        r_addr_next    = r_addr_reg;
        r_smp_next     = r_smp_reg;
        r_irq_next     = r_irq_reg;
        r_lviw_next    = r_lviw_reg;
        r_lvi_next     = r_lvi_reg;
        r_act_next     = r_act_reg;
        r_err_next     = r_err_reg;
        r_play_next    = r_play_reg;
        r_last_next    = r_last_reg;

        if (ctrl.go)
        begin
            unique case (ctrl.op)
                OP_NOP:
                begin
                end
                OP_LATCH:
                begin
                    if (cmd_accept)
                    begin
                        cmd_next    = command;
                        civ_next    = current_index;
                        halted_next = channel_halted;
                        act_next    = ACT_NONE;
                        err_next    = 1'b0;
                        lviw_next   = 1'b0;
                        lvi_next    = '0;
                    end
                end
                OP_STOP:
                begin
                    producing_next = 1'b0;
                    looping_next   = 1'b0;
                    queued_next    = '0;
                    cursor_next    = '0;
                    act_next       = ACT_STOP;
                end
                OP_START_INIT:
                begin
                    cursor_next    = '0;
                    looping_next   = loop_reg;
                    producing_next = 1'b1;
                    wslot_next     = '0;
                    seen_next      = '0;
                    queued_next    = '0;
                end
                OP_SET_ERR:
                begin
                    err_next = 1'b1;
                end
                OP_START_OK:
                begin
                    lviw_next = 1'b1;
                    lvi_next  = wslot_dec;
                    act_next  = ACT_RUN;
                end
                OP_CIV_SUB:
                begin
                    civ_next = civ_reg - IDX_W'(RING_DEPTH);
                end
                OP_ADV:
                begin
                    adv_next = (adv_sum >= DEPTH_W) ? adv_sum - DEPTH_W : adv_sum;
                end
                OP_RETIRE:
                begin
                    queued_next = (adv_reg >= queued_w) ? '0 : CNT_W'(queued_w - adv_reg);
                    seen_next   = civ_w[SLOT_W-1:0];
                end
                OP_POLL_ACT:
                begin
                    act_next = (halted_reg && (queued_reg != '0)) ? ACT_RESUME : ACT_NONE;
                end
                OP_CLR_CURSOR:
                begin
                    cursor_next = '0;
                end
                OP_REST:
                begin
                    rest_next = len_reg - cursor_reg;
                    addr_next = base_reg + cursor_reg;
                end
                OP_CHUNK:
                begin
                    // clamp to the chunk limit, round down to words unless that empties it
                    if (rest_reg >= CHUNK_V)
                    begin
                        chunk_next = CHUNK_W'(CHUNK_TOP);
                    end
                    else if (rest_reg >= MIN_ALIGNED)
                    begin
                        chunk_next = CHUNK_W'(rest_reg & ALIGN_MASK);
                    end
                    else
                    begin
                        chunk_next = CHUNK_W'(rest_reg);
                    end
                end
                OP_ADVANCE:
                begin
                    cursor_next = cursor_reg + 32'(chunk_reg);
                end
                OP_END_CHECK:
                begin
                    irq_next = 1'b0;
                    if (cursor_reg >= len_reg)
                    begin
                        if (looping_reg)
                        begin
                            cursor_next = '0;
                        end
                        else
                        begin
                            irq_next       = 1'b1;
                            producing_next = 1'b0;
                        end
                    end
                end
                OP_EMIT_DESC:
                begin
                    res_valid_next = 1'b1;
                    r_kind_next    = KIND_DESC;
                    r_idx_next     = wslot_w[IDX_W-1:0];
                    r_addr_next    = addr_reg;
                    r_smp_next     = chunk_reg[CHUNK_W-1:1];
                    r_irq_next     = irq_reg;
                    r_lviw_next    = per_entry;
                    r_lvi_next     = per_entry ? wslot_w[IDX_W-1:0] : '0;
                    r_act_next     = ACT_NONE;
                    r_err_next     = 1'b0;
                    r_play_next    = 1'b0;
                    r_last_next    = 1'b0;
                    wslot_next     = wslot_inc;
                    queued_next    = queued_reg + CNT_W'(1);
                end
                OP_EMIT_STATUS:
                begin
                    res_valid_next = 1'b1;
                    r_kind_next    = KIND_STATUS;
                    r_idx_next     = '0;
                    r_addr_next    = '0;
                    r_smp_next     = '0;
                    r_irq_next     = 1'b0;
                    r_lviw_next    = lviw_reg;
                    r_lvi_next     = lvi_w[IDX_W-1:0];
                    r_act_next     = act_reg;
                    r_err_next     = err_reg;
                    r_play_next    = play_now;
                    r_last_next    = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            len_reg  <= '0;
            loop_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_BASE:   base_reg <= cfg_data;
                CFG_LENGTH: len_reg  <= cfg_data;
                CFG_LOOP:   loop_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            producing_reg <= 1'b0;
            looping_reg   <= 1'b0;
            wslot_reg     <= '0;
            seen_reg      <= '0;
            queued_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cursor_reg    <= cursor_next;
            producing_reg <= producing_next;
            looping_reg   <= looping_next;
            wslot_reg     <= wslot_next;
            seen_reg      <= seen_next;
            queued_reg    <= queued_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        civ_reg    <= civ_next;
        halted_reg <= halted_next;
        act_reg    <= act_next;
        err_reg    <= err_next;
        lviw_reg   <= lviw_next;
        lvi_reg    <= lvi_next;
        rest_reg   <= rest_next;
        addr_reg   <= addr_next;
        chunk_reg  <= chunk_next;
        irq_reg    <= irq_next;
        adv_reg    <= adv_next;
        r_kind_reg <= r_kind_next;
        r_idx_reg  <= r_idx_next;
        r_addr_reg <= r_addr_next;
        r_smp_reg  <= r_smp_next;
        r_irq_reg  <= r_irq_next;
        r_lviw_reg <= r_lviw_next;
        r_lvi_reg  <= r_lvi_next;
        r_act_reg  <= r_act_next;
        r_err_reg  <= r_err_next;
        r_play_reg <= r_play_next;
        r_last_reg <= r_last_next;
    end

    assign res_valid        = res_valid_reg;
    assign kind             = r_kind_reg;
    assign entry_index      = r_idx_reg;
    assign entry_address    = r_addr_reg;
    assign entry_samples    = r_smp_reg;
    assign entry_interrupt  = r_irq_reg;
    assign lvi_write        = r_lviw_reg;
    assign last_valid_index = r_lvi_reg;
    assign channel_action   = r_act_reg;
    assign start_error      = r_err_reg;
    assign playing          = r_play_reg;
    assign last             = r_last_reg;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        queued_w <= DEPTH_W)
        else $error("queued count exceeds ring depth");

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (wslot_w < DEPTH_W) && (seen_w < DEPTH_W))
        else $error("ring slot outside the ring");

    a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (r_last_reg == r_kind_reg))
        else $error("closing flag and result kind disagree");

endmodule
`default_nettype wire

// ----- sim/drr_refill_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drr_refill_checker
// Watches the configuration, command and result channels of the descriptor
// ring refill unit. It keeps its own copy of the ring state, works out the
// descriptor and status transactions that each accepted command must return,
// and compares every accepted result with the oldest one still due.
// ----------------------------------------------------------------------------
module drr_refill_checker
    import drr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire logic                 cmd_valid,
    input  wire logic                 cmd_stall,
    input  wire logic [1:0]           command,
    input  wire logic [IDX_W-1:0]     current_index,
    input  wire logic                 channel_halted,
    input  wire logic                 res_valid,
    input  wire logic                 res_stall,
    input  wire logic                 kind,
    input  wire logic [IDX_W-1:0]     entry_index,
    input  wire logic [31:0]          entry_address,
    input  wire logic [SAMPLES_W-1:0] entry_samples,
    input  wire logic                 entry_interrupt,
    input  wire logic                 lvi_write,
    input  wire logic [IDX_W-1:0]     last_valid_index,
    input  wire logic [1:0]           channel_action,
    input  wire logic                 start_error,
    input  wire logic                 playing,
    input  wire logic                 last,
    output int                        mismatches,
    output int                        outstanding
);

    typedef struct packed {
        logic                 kind;
        logic [IDX_W-1:0]     idx;
        logic [31:0]          addr;
        logic [SAMPLES_W-1:0] samples;
        logic                 irq;
        logic                 lvi_wr;
        logic [IDX_W-1:0]     lvi;
        logic [1:0]           act;
        logic                 err;
        logic                 play;
        logic                 last;
    } ring_item_t;

    // Register copies
    logic [31:0]      base_reg;
    logic [31:0]      length_reg;
    logic             loop_reg;

    // Ring state copies
    logic [31:0]      cursor;
    logic             filling;
    logic             wrapping;
    logic [IDX_W-1:0] wr_slot;
    logic [IDX_W-1:0] seen_slot;
    int unsigned      queued;

    ring_item_t       due_items[$];
    int               fault_count;

    function automatic string item_text(ring_item_t it);
        return $sformatf({"kind=%0d idx=%0d addr=%h samples=%h irq=%0d lvi_wr=%0d",
                          " lvi=%0d act=%0d err=%0d play=%0d last=%0d"},
                         it.kind, it.idx, it.addr, it.samples, it.irq, it.lvi_wr,
                         it.lvi, it.act, it.err, it.play, it.last);
    endfunction

    task automatic clear_all();
        base_reg    = '0;
        length_reg  = '0;
        loop_reg    = 1'b0;
        cursor      = '0;
        filling     = 1'b0;
        wrapping    = 1'b0;
        wr_slot     = '0;
        seen_slot   = '0;
        queued      = 0;
        fault_count = 0;
        due_items.delete();
    endtask

    task automatic push_status(input logic lvi_wr, input logic [IDX_W-1:0] lvi,
                               input logic [1:0] act, input logic err,
                               input logic halted);
        ring_item_t st;
        st        = '0;
        st.kind   = KIND_STATUS;
        st.lvi_wr = lvi_wr;
        st.lvi    = lvi;
        st.act    = act;
        st.err    = err;
        st.play   = filling || (queued > 0) || !halted;
        st.last   = 1'b1;
        due_items.push_back(st);
    endtask

    // Cut chunks off the buffer until the ring is full or play runs out.
    task automatic refill_ring(input logic poll_lvi);
        logic [31:0] rest;
        logic [31:0] chunk;
        logic [31:0] addr;
        logic        irq;
        logic        done;
        ring_item_t  d;
        done = 1'b0;
        while (!done && queued < DEF_RING_DEPTH && filling)
        begin
            if (cursor < length_reg)
            begin
                rest  = length_reg - cursor;
                chunk = (rest > DEF_CHUNK_BYTES) ? 32'(DEF_CHUNK_BYTES) : rest;
                addr  = base_reg + cursor;
                irq   = 1'b0;
                chunk = chunk & ALIGN_MASK;
                if (chunk == 0)
                    chunk = rest;
                cursor = cursor + chunk;
                if (cursor >= length_reg)
                begin
                    if (wrapping)
                        cursor = '0;
                    else
                    begin
                        irq     = 1'b1;
                        filling = 1'b0;
                    end
                end
                d         = '0;
                d.kind    = KIND_DESC;
                d.idx     = wr_slot;
                d.addr    = addr;
                d.samples = chunk[SAMPLES_W:1];
                d.irq     = irq;
                d.lvi_wr  = poll_lvi;
                d.lvi     = poll_lvi ? wr_slot : '0;
                due_items.push_back(d);
                wr_slot = wr_slot + 1'b1;
                queued++;
            end
            else if (wrapping && length_reg != 0)
                cursor = '0;
            else
                done = 1'b1;
        end
    endtask

    task automatic run_command(input logic [1:0] op, input logic [IDX_W-1:0] civ,
                               input logic halted);
        logic [IDX_W-1:0] adv;
        logic [1:0]       act;
        act = ACT_NONE;
        case (op)
            CMD_START:
            begin
                if (length_reg == 0)
                    push_status(1'b0, '0, ACT_NONE, 1'b1, halted);
                else
                begin
                    cursor    = '0;
                    wrapping  = loop_reg;
                    filling   = 1'b1;
                    wr_slot   = '0;
                    seen_slot = '0;
                    queued    = 0;
                    refill_ring(1'b0);
                    if (queued == 0)
                        push_status(1'b0, '0, ACT_NONE, 1'b1, halted);
                    else
                        push_status(1'b1, wr_slot - 1'b1, ACT_RUN, 1'b0, halted);
                end
            end
            CMD_POLL:
            begin
                if (filling || queued > 0)
                begin
                    if (civ != seen_slot)
                    begin
                        adv       = civ - seen_slot;
                        queued    = (adv >= queued) ? 0 : queued - adv;
                        seen_slot = civ;
                    end
                    refill_ring(1'b1);
                    if (halted && queued > 0)
                        act = ACT_RESUME;
                end
                push_status(1'b0, '0, act, 1'b0, halted);
            end
            CMD_STOP:
            begin
                filling  = 1'b0;
                wrapping = 1'b0;
                queued   = 0;
                cursor   = '0;
                push_status(1'b0, '0, ACT_STOP, 1'b0, halted);
            end
            default:
                push_status(1'b0, '0, ACT_NONE, 1'b0, halted);
        endcase
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
        case (idx)
            CFG_BASE:   base_reg   = data;
            CFG_LENGTH: length_reg = data;
            CFG_LOOP:   loop_reg   = data[0];
            default:    ;
        endcase
    endtask

    task automatic check_item();
        ring_item_t got;
        ring_item_t want;
        got = '{kind, entry_index, entry_address, entry_samples, entry_interrupt,
                lvi_write, last_valid_index, channel_action, start_error, playing, last};
        if (due_items.size() == 0)
        begin
            if (fault_count < 10)
                $display("%0t: result with nothing due: %s", $realtime, item_text(got));
            fault_count++;
        end
        else
        begin
            want = due_items.pop_front();
            if (got !== want)
            begin
                if (fault_count < 10)
                begin
                    $display("%0t: result mismatch", $realtime);
                    $display("    expected %s", item_text(want));
                    $display("    actual   %s", item_text(got));
                end
                fault_count++;
            end
        end
    endtask

    // Results first: anything accepted now belongs to an older command.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_all();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
                check_item();
            if (cfg_valid && cfg_ready)
                write_register(cfg_index, cfg_data);
            if (cmd_valid && !cmd_stall)
                run_command(command, current_index, channel_halted);
            mismatches  <= fault_count;
            outstanding <= due_items.size();
        end
    end

endmodule
`default_nettype wire

// ----- sim/dma_descriptor_ring_refill_unit_tb.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dma_descriptor_ring_refill_unit_tb
// Drives start, poll and stop commands and register writes into the refill
// unit, with random idling on both channels, and leaves prediction and
// comparison to the checker that sits beside it.
// ----------------------------------------------------------------------------
module dma_descriptor_ring_refill_unit_tb
    import drr_pkg::*;
();

    // Spare codes: the unused command and the unused register index
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam logic [1:0] CFG_SPARE = 2'd3;

    localparam int ITEMS      = 320;
    localparam int IDLE_PCT   = 19;
    localparam int HOLD_OFF   = 16;    // cycles after the last status before a write
    localparam int DRAIN      = 60;    // cycles to wait out at the very end
    localparam int QUIET_MAX  = 4000;  // cycles without any transaction

    logic                 clk;
    logic                 rst_n          = 1'b0;
    logic                 cfg_valid      = 1'b0;
    logic                 cfg_ready;
    logic [1:0]           cfg_index      = '0;
    logic [31:0]          cfg_data       = '0;
    logic                 cmd_valid      = 1'b0;
    logic                 cmd_stall;
    logic [1:0]           command        = '0;
    logic [IDX_W-1:0]     current_index  = '0;
    logic                 channel_halted = 1'b0;
    logic                 res_valid;
    logic                 res_stall      = 1'b0;
    logic                 kind;
    logic [IDX_W-1:0]     entry_index;
    logic [31:0]          entry_address;
    logic [SAMPLES_W-1:0] entry_samples;
    logic                 entry_interrupt;
    logic                 lvi_write;
    logic [IDX_W-1:0]     last_valid_index;
    logic [1:0]           channel_action;
    logic                 start_error;
    logic                 playing;
    logic                 last;

    int                   mismatches;
    int                   outstanding;
    int                   items_sent   = 0;
    int                   quiet_cycles = 0;
    logic                 calm         = 1'b0;   // high: no idling on either side

    dma_descriptor_ring_refill_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd_valid        (cmd_valid),
        .cmd_stall        (cmd_stall),
        .command          (command),
        .current_index    (current_index),
        .channel_halted   (channel_halted),
        .res_valid        (res_valid),
        .res_stall        (res_stall),
        .kind             (kind),
        .entry_index      (entry_index),
        .entry_address    (entry_address),
        .entry_samples    (entry_samples),
        .entry_interrupt  (entry_interrupt),
        .lvi_write        (lvi_write),
        .last_valid_index (last_valid_index),
        .channel_action   (channel_action),
        .start_error      (start_error),
        .playing          (playing),
        .last             (last)
    );

    drr_refill_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd_valid        (cmd_valid),
        .cmd_stall        (cmd_stall),
        .command          (command),
        .current_index    (current_index),
        .channel_halted   (channel_halted),
        .res_valid        (res_valid),
        .res_stall        (res_stall),
        .kind             (kind),
        .entry_index      (entry_index),
        .entry_address    (entry_address),
        .entry_samples    (entry_samples),
        .entry_interrupt  (entry_interrupt),
        .lvi_write        (lvi_write),
        .last_valid_index (last_valid_index),
        .channel_action   (channel_action),
        .start_error      (start_error),
        .playing          (playing),
        .last             (last),
        .mismatches       (mismatches),
        .outstanding      (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: stall at random, except during the calm stretch.
    always @(posedge clk)
    begin
        if (calm)
            res_stall <= 1'b0;
        else
            res_stall <= ($urandom_range(99) < IDLE_PCT);
    end

    // Watchdog: end the run if no transaction moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_MAX)
        begin
            $display("dma_descriptor_ring_refill_unit_tb NOT OK");
            $finish;
        end
    end

    // Offer one command, idling first at random, and hold it until accepted.
    // Valid is only lowered during a gap, so back-to-back commands keep it high.
    task automatic send(input logic [1:0] op, input logic [IDX_W-1:0] civ,
                        input logic halted);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid      <= 1'b1;
        command        <= op;
        current_index  <= civ;
        channel_halted <= halted;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Drop valid and hold until every due result has arrived, then let the
    // sequencer wind down before anything touches the registers.
    task automatic settle();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (HOLD_OFF)
            @(posedge clk);
    endtask

    // One register write; call only after settle.
    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_ring(input logic [31:0] base, input logic [31:0] len,
                            input logic loop_on);
        settle();
        cfg_write(CFG_BASE, base);
        cfg_write(CFG_LENGTH, len);
        cfg_write(CFG_LOOP, {31'd0, loop_on});
    endtask

    // Mostly short buffers keep starts cheap; a few reach the full ring.
    function automatic logic [31:0] pick_length();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5)
            return 32'd0;
        else if (r < 35)
            return $urandom_range(1, 16);
        else if (r < 65)
            return $urandom_range(17, 4000);
        else if (r < 90)
            return $urandom_range(4001, 40 * DEF_CHUNK_BYTES);
        else
            return $urandom;
    endfunction

    function automatic logic [31:0] pick_base();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0)
            return 32'd0;
        else if (r == 1)
            return 32'hFFFF_FFFF - $urandom_range(0, 4000);
        else
            return $urandom;
    endfunction

    initial
    begin : stimulus
        logic [IDX_W-1:0] civ;
        int               polls;
        int               step;

        // Hold reset, then release it on a clock edge.
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- directed part ----------------
        // Idle poll straight out of reset, zero-length start refused,
        // spare command code, stop with nothing playing.
        send(CMD_POLL, 5'd31, 1'b1);
        send(CMD_START, 5'd0, 1'b0);
        send(CMD_SPARE, 5'd0, 1'b1);
        send(CMD_STOP, 5'd0, 1'b0);

        // Ten bytes near the top of the address space: address wraps past
        // 2^32, and the two-byte tail is too short to round down to 4.
        set_ring(32'hFFFF_FFFC, 32'd10, 1'b0);
        send(CMD_START, 5'd0, 1'b1);
        send(CMD_POLL, 5'd1, 1'b1);
        send(CMD_POLL, 5'd2, 1'b1);
        send(CMD_POLL, 5'd2, 1'b0);

        // Longest buffer in loop play fills the whole ring with full chunks;
        // the index then wraps round the ring.
        set_ring(32'h1000_0000, 32'hFFFF_FFFF, 1'b1);
        send(CMD_START, 5'd0, 1'b0);
        send(CMD_POLL, 5'd31, 1'b1);
        send(CMD_POLL, 5'd0, 1'b0);

        // Shrink the length under loop play, then drop it to zero.
        settle();
        cfg_write(CFG_LENGTH, 32'h0000_0100);
        send(CMD_POLL, 5'd16, 1'b1);
        settle();
        cfg_write(CFG_LENGTH, 32'd0);
        send(CMD_POLL, 5'd20, 1'b1);
        send(CMD_STOP, 5'd21, 1'b1);

        // Single play ending on an odd three-byte remainder.
        set_ring(32'h0000_0000, 32'h0002_0003, 1'b0);
        send(CMD_START, 5'd0, 1'b0);
        send(CMD_POLL, 5'd3, 1'b1);

        // Shrink the length under single play: refilling must stop, and a
        // repeated index must retire nothing.
        set_ring(32'h8000_0000, 32'h0040_0000, 1'b0);
        send(CMD_START, 5'd0, 1'b1);
        settle();
        cfg_write(CFG_SPARE, 32'hFFFF_FFFF);
        cfg_write(CFG_LENGTH, 32'h0000_0010);
        send(CMD_POLL, 5'd8, 1'b1);
        send(CMD_POLL, 5'd8, 1'b1);
        send(CMD_STOP, 5'd8, 1'b0);

        // ---------------- random part ----------------
        while (items_sent < ITEMS)
        begin
            // Leave a long stretch in the middle with no idling at all.
            calm = (items_sent >= 140 && items_sent < 200);
            if ($urandom_range(19) == 0)
            begin
                settle();
                cfg_write(CFG_SPARE, $urandom);
            end
            set_ring(pick_base(), pick_length(), 1'($urandom_range(1)));

            if ($urandom_range(99) < 85)
            begin
                // Well-formed play: start, then polls with the engine index
                // moving forward by small or occasionally large steps.
                civ = '0;
                send(CMD_START, 5'($urandom), 1'($urandom_range(1)));
                polls = $urandom_range(1, 12);
                for (int k = 0; k < polls; k++)
                begin
                    step = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(6);
                    civ  = civ + 5'(step);
                    if ($urandom_range(15) == 0)
                    begin
                        settle();
                        cfg_write(CFG_LENGTH, pick_length());
                    end
                    else if ($urandom_range(15) == 0)
                        settle();
                    if ($urandom_range(19) == 0)
                        send(2'($urandom_range(3)), 5'($urandom), 1'($urandom_range(1)));
                    else
                        send(CMD_POLL, civ, 1'($urandom_range(1)));
                end
                if ($urandom_range(3) == 0)
                    send(CMD_STOP, 5'($urandom), 1'($urandom_range(1)));
            end
            else
            begin
                // Noise: any command code with any index.
                repeat ($urandom_range(1, 6))
                    send(2'($urandom_range(3)), 5'($urandom), 1'($urandom_range(1)));
            end
        end
        calm = 1'b0;

        // ---------------- drain and verdict ----------------
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN)
            @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("dma_descriptor_ring_refill_unit_tb OK");
        else
            $display("dma_descriptor_ring_refill_unit_tb NOT OK");
        $finish;
    end

endmodule
`default_nettype wire

// ----- dma_descriptor_ring_refill_unit.f -----
rtl/core/drr_pkg.sv
rtl/core/drr_ucode_rom.sv
rtl/core/drr_sequencer.sv
rtl/core/drr_datapath.sv
rtl/core/dma_descriptor_ring_refill_unit.sv
sim/drr_refill_checker.sv
sim/dma_descriptor_ring_refill_unit_tb.sv
